// ===== design/gtc_pkg.sv =====
// Package: sizes, config register codes and shared types of the triangle counter.
package gtc_pkg;

  localparam int ID_W       = 32;
  localparam int MAX_NODES  = 1024;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int MAX_DEGREE = 64;
  localparam int POS_W      = $clog2(MAX_DEGREE);
  localparam int DEG_W      = POS_W + 1;
  localparam int ADDR_W     = NODE_W + POS_W;
  localparam int COUNT_W    = 11;
  localparam int HIT_W      = 22;
  localparam int EDGE_W     = 17;
  localparam int CFG_IDX_W  = 2;

  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd1;

  // Edge after offset removal and range check.
  typedef struct packed {
    logic [NODE_W-1:0] a;
    logic [NODE_W-1:0] b;
    logic              bad;
    logic              self_loop;
  } edge_info_t;

endpackage

// ===== design/gtc_edge_if.sv =====
// Interface: edge word channel.
interface gtc_edge_if;
  logic                    valid;
  logic                    ready;
  logic [gtc_pkg::ID_W-1:0] node_a;
  logic [gtc_pkg::ID_W-1:0] node_b;
  logic                    last_edge;

  modport source (output valid, node_a, node_b, last_edge, input ready);
  modport sink   (input valid, node_a, node_b, last_edge, output ready);
endinterface

// ===== design/gtc_result_if.sv =====
// Interface: result word channel.
interface gtc_result_if;
  logic                      valid;
  logic                      ready;
  logic [gtc_pkg::HIT_W-1:0]  triangle_hits;
  logic [gtc_pkg::EDGE_W-1:0] directed_edges;
  logic                      status;

  modport source (output valid, triangle_hits, directed_edges, status, input ready);
  modport sink   (input valid, triangle_hits, directed_edges, status, output ready);
endinterface

// ===== design/gtc_edge_check.sv =====
// Edge check: offset removal, range check and self-loop detection.
module gtc_edge_check (
  input  logic [gtc_pkg::ID_W-1:0]    node_a,
  input  logic [gtc_pkg::ID_W-1:0]    node_b,
  input  logic [gtc_pkg::ID_W-1:0]    node_offset,
  input  logic [gtc_pkg::COUNT_W-1:0] node_count,
  output gtc_pkg::edge_info_t         info
);

  logic [gtc_pkg::ID_W-1:0]    a_rel;
  logic [gtc_pkg::ID_W-1:0]    b_rel;
  logic [gtc_pkg::COUNT_W-1:0] lim;

  always_comb begin
    a_rel = node_a - node_offset;
    b_rel = node_b - node_offset;
    lim   = (node_count > gtc_pkg::COUNT_W'(gtc_pkg::MAX_NODES)) ?
            gtc_pkg::COUNT_W'(gtc_pkg::MAX_NODES) : node_count;
    info.a = a_rel[gtc_pkg::NODE_W-1:0];
    info.b = b_rel[gtc_pkg::NODE_W-1:0];
    info.bad = (a_rel >= gtc_pkg::ID_W'(lim)) || (b_rel >= gtc_pkg::ID_W'(lim));
    info.self_loop = (a_rel == b_rel);
  end

endmodule

// ===== design/graph_triangle_counter_top.sv =====
// Top level: streaming edge store and merge-based triangle counter.
//
//  channel   dir  word                                   accepted when
//  edges     in   node_a, node_b, last_edge              valid && ready
//  results   out  triangle_hits, directed_edges, status  valid && ready
//  wr_*      in   wr_index, wr_data                      wr_en
//
// Each edge runs a range check, two degree reads, one scan of the first list
// for a duplicate and two insertion shifts, one per direction. The last edge
// adds a count walk over all 1024 degree slots, with per neighbor a list
// search and merge. After reset and after each result a clearing pass over
// all 1024 slots zeroes the degree memory; no edge is taken meanwhile.
// Config writes are always taken.
// One edge is in work at a time. The result word sits in an output register,
// so a stalled receiver lets the block clear and take the next graph; it
// stops at the end of the next count walk until that register drains.
module graph_triangle_counter_top (
  input  logic                          clk,
  input  logic                          rst,
  gtc_edge_if.sink                      edges,
  gtc_result_if.source                  results,
  input  logic                          wr_en,
  input  logic [gtc_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [gtc_pkg::ID_W-1:0]      wr_data
);

  typedef enum logic [20:0] {
    S_CLEAR = 21'h000001, S_IDLE = 21'h000002, S_CHECK = 21'h000004,
    S_DEGA  = 21'h000008, S_DEGB = 21'h000010, S_DUP   = 21'h000020,
    S_DUPW  = 21'h000040, S_INS  = 21'h000080, S_INSW  = 21'h000100,
    S_DONE  = 21'h000200, S_CV   = 21'h000400, S_CVD   = 21'h000800,
    S_CJ    = 21'h001000, S_CJD  = 21'h002000, S_CUD   = 21'h004000,
    S_FA    = 21'h008000, S_FAD  = 21'h010000, S_MX    = 21'h020000,
    S_MXD   = 21'h040000, S_MYD  = 21'h080000, S_OUT   = 21'h100000
  } state_t;

  localparam int NW = gtc_pkg::NODE_W;
  localparam int PW = gtc_pkg::POS_W;
  localparam int DW = gtc_pkg::DEG_W;

  state_t state, state_next;

  // config
  logic [gtc_pkg::ID_W-1:0]    node_offset;
  logic [gtc_pkg::COUNT_W-1:0] node_count;

  // graph totals
  logic [gtc_pkg::EDGE_W-1:0] edge_total;
  logic                       error_seen;
  logic [gtc_pkg::HIT_W-1:0]  hits;

  // output register
  logic                       res_valid, out_load;
  logic [gtc_pkg::HIT_W-1:0]  res_hits;
  logic [gtc_pkg::EDGE_W-1:0] res_edges;
  logic                       res_status;

  // edge in work
  gtc_pkg::edge_info_t info, edge_r;
  logic                last_r;
  logic [DW-1:0]       deg_a, deg_b, idx;
  logic [NW-1:0]       ins_node, ins_nb;
  logic [DW-1:0]       ins_deg, k;
  logic                second;

  // count walk
  logic [NW:0]   v;
  logic [DW-1:0] lv, lu, j, i, jj;
  logic [NW-1:0] u, x;
  logic [NW-1:0] clr;

  // memories
  logic [NW-1:0] adj_mem [2**gtc_pkg::ADDR_W];
  logic [DW-1:0] deg_mem [gtc_pkg::MAX_NODES];
  logic                      adj_re, adj_we, deg_re, deg_we;
  logic [gtc_pkg::ADDR_W-1:0] adj_raddr, adj_waddr;
  logic [NW-1:0]             adj_wdata, adj_rdata, deg_raddr, deg_waddr;
  logic [DW-1:0]             deg_wdata, deg_rdata;
  logic                      ins_fin, in_acc;

  gtc_edge_check u_check (
    .node_a      (edges.node_a),
    .node_b      (edges.node_b),
    .node_offset (node_offset),
    .node_count  (node_count),
    .info        (info)
  );

  assign edges.ready           = (state == S_IDLE);
  assign in_acc                = edges.valid && edges.ready;
  assign results.valid         = res_valid;
  assign results.triangle_hits = res_hits;
  assign results.directed_edges = res_edges;
  assign results.status        = res_status;

  // tally moves to the output register once it is free or draining
  assign out_load = (state == S_OUT) && (!res_valid || results.ready);

  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_waddr] <= adj_wdata;
    if (adj_re) adj_rdata <= adj_mem[adj_raddr];
    if (deg_we) deg_mem[deg_waddr] <= deg_wdata;
    if (deg_re) deg_rdata <= deg_mem[deg_raddr];
  end

  // insertion ends: either the list head is reached or the entry below is not larger
  assign ins_fin = ((state == S_INS) && (k == '0)) ||
                   ((state == S_INSW) && !(adj_rdata > ins_nb));

  // memory control and next state
  always_comb begin
    adj_re = 1'b0; adj_raddr = '0; adj_we = 1'b0; adj_waddr = '0; adj_wdata = '0;
    deg_re = 1'b0; deg_raddr = '0; deg_we = 1'b0; deg_waddr = '0; deg_wdata = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        deg_we = 1'b1; deg_waddr = clr;
        if (clr == {NW{1'b1}}) state_next = S_IDLE;
      end
      S_IDLE: if (in_acc) state_next = S_CHECK;
      S_CHECK: begin
        if (edge_r.bad || edge_r.self_loop) begin
          state_next = S_DONE;
        end else begin
          deg_re = 1'b1; deg_raddr = edge_r.a; state_next = S_DEGA;
        end
      end
      S_DEGA: begin
        deg_re = 1'b1; deg_raddr = edge_r.b; state_next = S_DEGB;
      end
      S_DEGB: state_next = S_DUP;
      S_DUP: begin
        if (idx == deg_a) begin
          if (deg_a == DW'(gtc_pkg::MAX_DEGREE) || deg_b == DW'(gtc_pkg::MAX_DEGREE))
            state_next = S_DONE;
          else
            state_next = S_INS;
        end else begin
          adj_re = 1'b1; adj_raddr = {edge_r.a, idx[PW-1:0]}; state_next = S_DUPW;
        end
      end
      S_DUPW: state_next = (adj_rdata == edge_r.b) ? S_DONE : S_DUP;
      S_INS: begin
        if (k == '0) begin
          adj_we = 1'b1; adj_waddr = {ins_node, {PW{1'b0}}}; adj_wdata = ins_nb;
        end else begin
          adj_re = 1'b1; adj_raddr = {ins_node, PW'(k - DW'(1))}; state_next = S_INSW;
        end
      end
      S_INSW: begin
        adj_we = 1'b1; adj_waddr = {ins_node, k[PW-1:0]};
        if (adj_rdata > ins_nb) begin
          adj_wdata = adj_rdata; state_next = S_INS;
        end else begin
          adj_wdata = ins_nb;
        end
      end
      S_DONE: state_next = last_r ? S_CV : S_IDLE;
      S_CV: begin
        if (v[NW]) begin
          state_next = S_OUT;
        end else begin
          deg_re = 1'b1; deg_raddr = v[NW-1:0]; state_next = S_CVD;
        end
      end
      S_CVD: state_next = S_CJ;
      S_CJ: begin
        if (j == lv) begin
          state_next = S_CV;
        end else begin
          adj_re = 1'b1; adj_raddr = {v[NW-1:0], j[PW-1:0]}; state_next = S_CJD;
        end
      end
      S_CJD: begin
        deg_re = 1'b1; deg_raddr = adj_rdata; state_next = S_CUD;
      end
      S_CUD: state_next = S_FA;
      S_FA: begin
        if (jj == lu) begin
          state_next = S_MX;
        end else begin
          adj_re = 1'b1; adj_raddr = {u, jj[PW-1:0]}; state_next = S_FAD;
        end
      end
      S_FAD: state_next = (adj_rdata > u) ? S_MX : S_FA;
      S_MX: begin
        if (i == lv || jj == lu) begin
          state_next = S_CJ;
        end else begin
          adj_re = 1'b1; adj_raddr = {v[NW-1:0], i[PW-1:0]}; state_next = S_MXD;
        end
      end
      S_MXD: begin
        adj_re = 1'b1; adj_raddr = {u, jj[PW-1:0]}; state_next = S_MYD;
      end
      S_MYD: state_next = S_MX;
      S_OUT: if (out_load) state_next = S_CLEAR;
      default: state_next = S_IDLE;
    endcase
    if (ins_fin) begin
      deg_we = 1'b1; deg_waddr = ins_node; deg_wdata = ins_deg + DW'(1);
      state_next = second ? S_DONE : S_INS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      clr         <= '0;
      edge_total  <= '0;
      error_seen  <= 1'b0;
      hits        <= '0;
      res_valid   <= 1'b0;
      node_offset <= '0;
      node_count  <= gtc_pkg::COUNT_W'(gtc_pkg::MAX_NODES);
    end else begin
      state <= state_next;
      if (out_load)
        res_valid <= 1'b1;
      else if (results.ready)
        res_valid <= 1'b0;
      if (wr_en) begin
        case (wr_index)
          gtc_pkg::CFG_NODE_OFFSET: node_offset <= wr_data;
          gtc_pkg::CFG_NODE_COUNT:  node_count  <= wr_data[gtc_pkg::COUNT_W-1:0];
          default: ;
        endcase
      end
      case (state)
        S_CLEAR: clr <= clr + NW'(1);
        S_IDLE: if (in_acc) begin
          edge_r <= info;
          last_r <= edges.last_edge;
        end
        S_CHECK: if (edge_r.bad) error_seen <= 1'b1;
        S_DEGA:  deg_a <= deg_rdata;
        S_DEGB: begin
          deg_b <= deg_rdata;
          idx   <= '0;
        end
        S_DUP: if (idx == deg_a) begin
          if (deg_a == DW'(gtc_pkg::MAX_DEGREE) || deg_b == DW'(gtc_pkg::MAX_DEGREE))
            error_seen <= 1'b1;
          ins_node <= edge_r.a;
          ins_nb   <= edge_r.b;
          ins_deg  <= deg_a;
          k        <= deg_a;
          second   <= 1'b0;
        end
        S_DUPW: idx <= idx + DW'(1);
        S_INSW: if (adj_rdata > ins_nb) k <= k - DW'(1);
        S_DONE: v <= '0;
        S_CV: ;
        S_CVD: begin
          lv <= deg_rdata;
          j  <= '0;
        end
        S_CJ: if (j == lv) v <= v + (NW+1)'(1);
        S_CJD: u <= adj_rdata;
        S_CUD: begin
          lu <= deg_rdata;
          i  <= j + DW'(1);
          jj <= '0;
        end
        S_FAD: if (!(adj_rdata > u)) jj <= jj + DW'(1);
        S_MX: if (i == lv || jj == lu) j <= j + DW'(1);
        S_MXD: x <= adj_rdata;
        S_MYD: begin
          if (x == adj_rdata) begin
            if (hits != gtc_pkg::HIT_MAX) hits <= hits + gtc_pkg::HIT_W'(1);
            i  <= i + DW'(1);
            jj <= jj + DW'(1);
          end else if (x < adj_rdata) begin
            i <= i + DW'(1);
          end else begin
            jj <= jj + DW'(1);
          end
        end
        S_OUT: if (out_load) begin
          res_hits   <= hits;
          res_edges  <= edge_total;
          res_status <= error_seen;
          clr        <= '0;
          edge_total <= '0;
          error_seen <= 1'b0;
          hits       <= '0;
        end
        default: ;
      endcase
      // second direction follows the first; edge counted after both
      if (ins_fin) begin
        if (!second) begin
          ins_node <= edge_r.b;
          ins_nb   <= edge_r.a;
          ins_deg  <= deg_b;
          k        <= deg_b;
          second   <= 1'b1;
        end else begin
          edge_total <= edge_total + gtc_pkg::EDGE_W'(2);
        end
      end
    end
  end

  // a list never grows past its capacity
  a_deg_cap: assert property (@(posedge clk) disable iff (rst)
    deg_we |-> deg_wdata <= DW'(gtc_pkg::MAX_DEGREE))
    else $error("degree write above capacity");

  // shift reads never collide with the write of the same cycle
  a_adj_rw: assert property (@(posedge clk) disable iff (rst)
    (adj_we && adj_re) |-> adj_waddr != adj_raddr)
    else $error("adjacency read and write to one address");

  // an accepted edge is checked in the next cycle
  a_accept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == S_CHECK)
    else $error("accepted edge not checked");

  // a result leaves only after a count walk has finished
  a_result: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state) == S_OUT)
    else $error("result without count walk");

endmodule

// ===== tb/tb.sv =====
// Testbench for graph_triangle_counter_top: edge streams in, triangle tallies checked.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Expected result word of one graph
  typedef struct {
    logic [gtc_pkg::HIT_W-1:0]  hits;
    logic [gtc_pkg::EDGE_W-1:0] dir_edges;
    logic                       status;
  } tally_t;

  // Scoreboard: keeps its own copy of the edge store and the registers,
  // predicts a tally on every last edge and checks tallies in order.
  class triangle_scoreboard;
    bit [gtc_pkg::NODE_W-1:0] adj [gtc_pkg::MAX_NODES][gtc_pkg::MAX_DEGREE];
    int              deg [gtc_pkg::MAX_NODES];
    int              edge_sum;
    bit              dropped;
    bit [gtc_pkg::ID_W-1:0] offset;
    int              slots;
    tally_t          waiting [$];
    int              errors;
    int              checked;

    function new();
      offset = '0;
      slots  = gtc_pkg::MAX_NODES;
      foreach (deg[i]) deg[i] = 0;
    endfunction

    function void set_reg(logic [gtc_pkg::CFG_IDX_W-1:0] idx,
                          logic [gtc_pkg::ID_W-1:0] data);
      if (idx == gtc_pkg::CFG_NODE_OFFSET) offset = data;
      else if (idx == gtc_pkg::CFG_NODE_COUNT) slots = int'(data[gtc_pkg::COUNT_W-1:0]);
    endfunction

    function int pending();
      return waiting.size();
    endfunction

    function bit linked(int v, int u);
      for (int i = 0; i < deg[v]; i++)
        if (adj[v][i] == u) return 1;
      return 0;
    endfunction

    function void place(int v, int u);
      int pos;
      pos = 0;
      while (pos < deg[v] && adj[v][pos] <= u) pos++;
      for (int k = deg[v]; k > pos; k--) adj[v][k] = adj[v][k-1];
      adj[v][pos] = gtc_pkg::NODE_W'(u);
      deg[v]++;
    endfunction

    function int above(int v, int x);
      for (int i = 0; i < deg[v]; i++)
        if (adj[v][i] > x) return i;
      return deg[v];
    endfunction

    function int common(int v, int i, int u, int j);
      int c;
      c = 0;
      while (i < deg[v] && j < deg[u]) begin
        if (adj[v][i] == adj[u][j]) begin
          c++; i++; j++;
        end else if (adj[v][i] < adj[u][j]) i++;
        else j++;
      end
      return c;
    endfunction

    function void store_edge(bit [gtc_pkg::ID_W-1:0] ida, bit [gtc_pkg::ID_W-1:0] idb);
      bit [gtc_pkg::ID_W-1:0] a, b;
      int lim;
      lim = (slots < gtc_pkg::MAX_NODES) ? slots : gtc_pkg::MAX_NODES;
      a = ida - offset;
      b = idb - offset;
      if (a >= lim || b >= lim) begin
        dropped = 1;
        return;
      end
      if (a == b || linked(a, b)) return;
      if (deg[a] >= gtc_pkg::MAX_DEGREE || deg[b] >= gtc_pkg::MAX_DEGREE) begin
        dropped = 1;
        return;
      end
      place(a, b);
      place(b, a);
      edge_sum = (edge_sum + 2) & ((1 << gtc_pkg::EDGE_W) - 1);
    endfunction

    function void note_edge(bit [gtc_pkg::ID_W-1:0] a, bit [gtc_pkg::ID_W-1:0] b, bit last);
      tally_t t;
      longint hits;
      store_edge(a, b);
      if (!last) return;
      hits = 0;
      for (int v = 0; v < gtc_pkg::MAX_NODES; v++)
        for (int j = 0; j < deg[v]; j++) begin
          int u;
          u = adj[v][j];
          hits += common(v, above(v, u), u, above(u, u));
          if (hits > gtc_pkg::HIT_MAX) hits = gtc_pkg::HIT_MAX;
        end
      t.hits      = gtc_pkg::HIT_W'(hits);
      t.dir_edges = gtc_pkg::EDGE_W'(edge_sum);
      t.status    = dropped;
      waiting = {waiting, t};
      foreach (deg[i]) deg[i] = 0;
      edge_sum = 0;
      dropped  = 0;
    endfunction

    task report(string what, longint got, longint want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_result(logic [gtc_pkg::HIT_W-1:0] h, logic [gtc_pkg::EDGE_W-1:0] e, logic s);
      tally_t t;
      if (waiting.size() == 0) begin
        report("unexpected result, hits", h, 0);
        return;
      end
      t = waiting.pop_front();
      checked++;
      if (h !== t.hits) report("triangle_hits", h, t.hits);
      if (e !== t.dir_edges) report("directed_edges", e, t.dir_edges);
      if (s !== t.status) report("status", s, t.status);
    endtask
  endclass

  localparam int STALL_LIMIT = 200000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 15000;   // long receiver hold-off, past one clear and walk

  logic clk;
  logic rst;
  logic wr_en;
  logic [gtc_pkg::CFG_IDX_W-1:0] wr_index;
  logic [gtc_pkg::ID_W-1:0] wr_data;

  gtc_edge_if   edges_if ();
  gtc_result_if res_if ();

  graph_triangle_counter_top uut (
    .clk      (clk),
    .rst      (rst),
    .edges    (edges_if),
    .results  (res_if),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  triangle_scoreboard sb = new();

  int tx_idle_pct = 12;   // sender gap chance, percent
  int rx_idle_pct = 55;   // receiver stall chance, percent
  bit hold_req = 0;
  int words_sent = 0;
  int graphs = 0;
  int idle_run = 0;
  int lim;                // current usable node slots

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // block fills up and has to push back on the edge channel.
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Result monitor: sample at the edge, before the block updates
  always @(posedge clk)
    if (!rst && res_if.valid && res_if.ready)
      sb.check_result(res_if.triangle_hits, res_if.directed_edges, res_if.status);

  // Watchdog: any handshake on either channel restarts the count
  always @(posedge clk) begin
    if ((edges_if.valid && edges_if.ready) || (res_if.valid && res_if.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run > STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
      $display("tb: errors");
      $finish;
    end
  end

  // One edge word; valid stays up across back-to-back words
  task automatic push_edge(input logic [gtc_pkg::ID_W-1:0] a,
                           input logic [gtc_pkg::ID_W-1:0] b,
                           input logic last);
    int gap;
    gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      edges_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edges_if.valid     <= 1'b1;
    edges_if.node_a    <= a;
    edges_if.node_b    <= b;
    edges_if.last_edge <= last;
    @(posedge clk);
    while (!edges_if.ready) @(posedge clk);
    sb.note_edge(a, b, last);
    words_sent++;
  endtask

  // Drop valid, let every tally drain, then let the block settle
  task automatic go_quiet(input int settle);
    edges_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // One register write; the write enable is then dropped again
  task automatic write_reg(input logic [gtc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [gtc_pkg::ID_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    wr_en <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Node id from a slot index under the current offset
  function automatic logic [gtc_pkg::ID_W-1:0] id_of(int r);
    return sb.offset + gtc_pkg::ID_W'(r);
  endfunction

  // Random graph: well-formed edges over a window of slots with some noise
  // (out of range ids, self loops, repeated edges). Star graphs hang most
  // of their edges on one node, short of a full list.
  task automatic random_graph();
    int n, span, base, a, b, pa, pb, roll;
    bit star;
    star = (lim >= gtc_pkg::MAX_DEGREE + 4) && ($urandom_range(14) == 0);
    n    = star ? gtc_pkg::MAX_DEGREE + $urandom_range(2, 5) : $urandom_range(5, 40);
    span = (lim < 4) ? 4 : $urandom_range(4, (lim < 20) ? lim : 20);
    base = (lim > span) ? (($urandom_range(3) == 0) ? lim - span : $urandom_range(lim - span))
                        : 0;
    pa = base;
    pb = base + 1;
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (star) begin
        a = base;
        b = base + 1 + i;
        if (i % 9 == 8) a = b - 1;         // leaf-to-leaf closes triangles
      end else begin
        a = base + $urandom_range(span - 1);
        b = base + $urandom_range(span - 1);
      end
      if (roll < 5) b = a;                        // self loop
      else if (roll < 12) begin                   // repeat, reversed
        a = pb;
        b = pa;
      end else if (roll < 17) b = lim + $urandom_range(3);
      if (roll >= 17 && roll < 20)
        push_edge($urandom(), id_of(b), i == n - 1);
      else
        push_edge(id_of(a), id_of(b), i == n - 1);
      pa = a;
      pb = b;
    end
    graphs++;
  endtask

  // Pick new register values; extremes come up often
  task automatic new_settings();
    int c;
    case ($urandom_range(5))
      0: write_reg(gtc_pkg::CFG_NODE_OFFSET, '0);
      1: write_reg(gtc_pkg::CFG_NODE_OFFSET, 32'hFFFF_FFFF - $urandom_range(30));
      default: write_reg(gtc_pkg::CFG_NODE_OFFSET, $urandom());
    endcase
    case ($urandom_range(9))
      0: c = 0;
      1: c = 1;
      2: c = gtc_pkg::MAX_NODES;
      3: c = 2047;
      4: c = gtc_pkg::MAX_NODES + 1;
      5: c = $urandom_range(70, 200);
      default: c = $urandom_range(2, 24);
    endcase
    write_reg(gtc_pkg::CFG_NODE_COUNT, gtc_pkg::ID_W'(c));
    lim = (c < gtc_pkg::MAX_NODES) ? c : gtc_pkg::MAX_NODES;
  endtask

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = '0;
    wr_data = '0;
    edges_if.valid = 1'b0;
    edges_if.node_a = '0;
    edges_if.node_b = '0;
    edges_if.last_edge = 1'b0;
    lim = gtc_pkg::MAX_NODES;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset settings; one triangle, self loop, repeat, top slot,
    // id just past the range
    push_edge(0, 1, 0);
    push_edge(1, 2, 0);
    push_edge(2, 0, 0);
    push_edge(1, 1, 0);
    push_edge(1, 0, 0);
    push_edge(1023, 0, 0);
    push_edge(1024, 5, 0);
    push_edge(0, 2, 1);
    // K4 in the top slots: four triangles, twelve hits
    push_edge(1020, 1021, 0);
    push_edge(1020, 1022, 0);
    push_edge(1020, 1023, 0);
    push_edge(1021, 1022, 0);
    push_edge(1021, 1023, 0);
    push_edge(1022, 1023, 1);
    go_quiet(1500);

    // Offset near the top of the id space; count drops mid-graph,
    // entries stored above the new count still take part in the tally
    write_reg(gtc_pkg::CFG_NODE_OFFSET, 32'hFFFF_FFF0);
    write_reg(gtc_pkg::CFG_NODE_COUNT, 8);
    lim = 8;
    push_edge(32'hFFFF_FFF7, 32'hFFFF_FFF0, 0);
    push_edge(32'hFFFF_FFF6, 32'hFFFF_FFF7, 0);
    push_edge(32'hFFFF_FFF0, 32'hFFFF_FFF6, 0);
    push_edge(32'hFFFF_FFF8, 32'hFFFF_FFF1, 0);
    go_quiet(600);
    write_reg(gtc_pkg::CFG_NODE_COUNT, 4);
    lim = 4;
    push_edge(32'hFFFF_FFF6, 32'hFFFF_FFF1, 0);
    push_edge(32'hFFFF_FFF0, 32'hFFFF_FFF1, 1);
    go_quiet(1500);
    // Zero node count: every edge is out of range
    write_reg(gtc_pkg::CFG_NODE_COUNT, 0);
    lim = 0;
    push_edge(32'hFFFF_FFF0, 32'hFFFF_FFF1, 1);
    go_quiet(1500);
    write_reg(3, 32'h1234_5678);  // unused index, must be ignored
    write_reg(2, 32'hFFFF_FFFF);
    write_reg(gtc_pkg::CFG_NODE_OFFSET, '0);
    write_reg(gtc_pkg::CFG_NODE_COUNT, 12);
    lim = 12;

    // Random graphs: receiver-heavy stalling, then sender-heavy idling with one long
    // hold-off, then full rate
    while (words_sent < 1320) begin
      if (words_sent < 450) begin
        tx_idle_pct = 12;
        rx_idle_pct = 55;
      end else if (words_sent < 900) begin
        if (tx_idle_pct != 55) hold_req = 1;
        tx_idle_pct = 55;
        rx_idle_pct = 12;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_graph();
      if ($urandom_range(5) == 0) begin
        go_quiet(1500);
        new_settings();
      end
    end

    go_quiet(2000);
    $display("covered %0d edge words in %0d graphs, %0d tallies checked",
             words_sent, graphs + 4, sb.checked);
    $display("settings varied over offset wrap, zero/one/full/oversized node count");
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
